// ===== sv/tgarle_pkg.sv =====
package tgarle_pkg;

	// result kinds on the output tuser
	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RUN    = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	// error codes
	typedef enum logic [1:0] {
		ERR_COLORMAP = 2'd0,
		ERR_IMG_TYPE = 2'd1,
		ERR_DEPTH    = 2'd2
	} err_t;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned OUT_DATA_W = 112;

	// compact result record between front and back
	// header: data_a = {height, width}, count[2:0] = {flip_v, flip_h, alpha}
	// run:    data_a = color, data_b = first pixel, count = run length
	// error:  code
	typedef struct packed {
		kind_t       kind;
		err_t        code;
		logic [31:0] data_a;
		logic [31:0] data_b;
		logic [7:0]  count;
		logic        last;
	} rec_t;

	// handshake between queue and back end
	typedef struct packed {
		logic valid;
		rec_t rec;
	} rec_chan_t;

endpackage

// ===== sv/tgarle_front.sv =====
module tgarle_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	input  logic [7:0]      byte_data,
	input  logic            byte_start,
	input  logic            space_ok,
	output logic            push,
	output tgarle_pkg::rec_t push_rec
);
	import tgarle_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_ID,
		PH_PACKET,
		PH_COLOR
	} phase_t;

	localparam logic [4:0] HDR_ID_LEN   = 5'd0;
	localparam logic [4:0] HDR_CMAP     = 5'd1;
	localparam logic [4:0] HDR_TYPE     = 5'd2;
	localparam logic [4:0] HDR_WIDTH_L  = 5'd12;
	localparam logic [4:0] HDR_WIDTH_H  = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_L = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_H = 5'd15;
	localparam logic [4:0] HDR_DEPTH    = 5'd16;
	localparam logic [4:0] HDR_DESC     = 5'd17;

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] DEPTH_24 = 8'd24;
	localparam logic [7:0] DEPTH_32 = 8'd32;

	phase_t      phase_q, phase_d, phase_cur;
	logic [4:0]  hidx_q, hidx_d, idx;
	logic [7:0]  id_q, id_d;
	logic        comp_q, comp_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        four_q, four_d;
	logic [1:0]  flip_q, flip_d;
	logic [31:0] tot_q;
	logic [31:0] pos_q, pos_d;
	logic [31:0] rem_q, rem_d;
	logic [7:0]  pkt_q, pkt_d;
	logic        run_q, run_d;
	logic [23:0] acc_q, acc_d;
	logic [1:0]  bidx_q, bidx_d;
	logic        accept;
	logic [7:0]  pcount;
	logic [7:0]  rcount;
	logic [1:0]  last_idx;
	logic [31:0] color;

	assign accept = byte_valid & space_ok;

	always_comb begin
		phase_cur = byte_start ? PH_HEADER : phase_q;
		idx       = byte_start ? 5'd0 : hidx_q;
		phase_d   = phase_cur;
		hidx_d    = hidx_q;
		id_d      = id_q;
		comp_d    = byte_start ? 1'b0 : comp_q;
		width_d   = width_q;
		height_d  = height_q;
		four_d    = byte_start ? 1'b0 : four_q;
		flip_d    = byte_start ? 2'b00 : flip_q;
		pos_d     = byte_start ? 32'd0 : pos_q;
		rem_d     = rem_q;
		pkt_d     = byte_start ? 8'd0 : pkt_q;
		run_d     = byte_start ? 1'b0 : run_q;
		acc_d     = acc_q;
		bidx_d    = byte_start ? 2'd0 : bidx_q;
		push      = 1'b0;
		push_rec  = '0;
		pcount    = {1'b0, byte_data[6:0]} + 8'd1;
		rcount    = 8'd1;
		last_idx  = four_q ? 2'd3 : 2'd2;
		color     = four_q ? {byte_data, acc_q} : {8'h00, byte_data, acc_q[15:0]};

		unique case (phase_cur)
			PH_HEADER: begin
				hidx_d = idx + 5'd1;
				case (idx)
					HDR_ID_LEN: id_d = byte_data;
					HDR_CMAP: begin
						if (byte_data != 8'd0) begin
							push          = 1'b1;
							push_rec.kind = KIND_ERROR;
							push_rec.code = ERR_COLORMAP;
							phase_d       = PH_IDLE;
						end
					end
					HDR_TYPE: begin
						if (byte_data != TYPE_RAW && byte_data != TYPE_RLE) begin
							push          = 1'b1;
							push_rec.kind = KIND_ERROR;
							push_rec.code = ERR_IMG_TYPE;
							phase_d       = PH_IDLE;
						end
						comp_d = (byte_data == TYPE_RLE);
					end
					HDR_WIDTH_L:  width_d  = {8'h00, byte_data};
					HDR_WIDTH_H:  width_d  = {byte_data, width_q[7:0]};
					HDR_HEIGHT_L: height_d = {8'h00, byte_data};
					HDR_HEIGHT_H: height_d = {byte_data, height_q[7:0]};
					HDR_DEPTH: begin
						if (byte_data != DEPTH_32 && byte_data != DEPTH_24) begin
							push          = 1'b1;
							push_rec.kind = KIND_ERROR;
							push_rec.code = ERR_DEPTH;
							phase_d       = PH_IDLE;
						end
						four_d = (byte_data == DEPTH_32);
					end
					HDR_DESC: begin
						flip_d          = {byte_data[5], byte_data[4]};
						pos_d           = 32'd0;
						rem_d           = tot_q;
						push            = 1'b1;
						push_rec.kind   = KIND_HEADER;
						push_rec.data_a = {height_q, width_q};
						push_rec.count  = {5'd0, byte_data[5], byte_data[4], four_q};
						push_rec.last   = (tot_q == 32'd0);
						bidx_d          = 2'd0;
						if (tot_q == 32'd0) begin
							phase_d = PH_IDLE;
						end else if (id_q != 8'd0) begin
							phase_d = PH_ID;
						end else begin
							phase_d = comp_q ? PH_PACKET : PH_COLOR;
						end
					end
					default: ;
				endcase
			end
			PH_ID: begin
				id_d = id_q - 8'd1;
				if (id_q == 8'd1) begin
					bidx_d  = 2'd0;
					phase_d = comp_q ? PH_PACKET : PH_COLOR;
				end
			end
			PH_PACKET: begin
				// clamp the packet at the image end
				pkt_d   = (rem_q < {24'd0, pcount}) ? rem_q[7:0] : pcount;
				run_d   = byte_data[7];
				bidx_d  = 2'd0;
				phase_d = PH_COLOR;
			end
			PH_COLOR: begin
				if (bidx_q < last_idx) begin
					case (bidx_q)
						2'd0:    acc_d[7:0]   = byte_data;
						2'd1:    acc_d[15:8]  = byte_data;
						default: acc_d[23:16] = byte_data;
					endcase
					bidx_d = bidx_q + 2'd1;
				end else begin
					if (comp_q && run_q && pkt_q != 8'd0) begin
						rcount = pkt_q;
					end
					bidx_d          = 2'd0;
					push            = 1'b1;
					push_rec.kind   = KIND_RUN;
					push_rec.data_a = color;
					push_rec.data_b = pos_q;
					push_rec.count  = rcount;
					push_rec.last   = (rem_q <= {24'd0, rcount});
					pos_d           = pos_q + {24'd0, rcount};
					rem_d           = rem_q - {24'd0, rcount};
					if (comp_q) begin
						pkt_d = (pkt_q >= rcount) ? pkt_q - rcount : 8'd0;
					end
					if (rem_q <= {24'd0, rcount}) begin
						phase_d = PH_IDLE;
					end else if (comp_q && pkt_d == 8'd0) begin
						phase_d = PH_PACKET;
					end
				end
			end
			default: ;
		endcase

		if (!accept) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			hidx_q   <= '0;
			id_q     <= '0;
			comp_q   <= 1'b0;
			width_q  <= '0;
			height_q <= '0;
			four_q   <= 1'b0;
			flip_q   <= '0;
			tot_q    <= '0;
			pos_q    <= '0;
			rem_q    <= '0;
			pkt_q    <= '0;
			run_q    <= 1'b0;
			acc_q    <= '0;
			bidx_q   <= '0;
		end else begin
			// pixel total ready two bytes after the height is complete
			tot_q <= {16'd0, width_q} * {16'd0, height_q};
			if (accept) begin
				phase_q  <= phase_d;
				hidx_q   <= hidx_d;
				id_q     <= id_d;
				comp_q   <= comp_d;
				width_q  <= width_d;
				height_q <= height_d;
				four_q   <= four_d;
				flip_q   <= flip_d;
				pos_q    <= pos_d;
				rem_q    <= rem_d;
				pkt_q    <= pkt_d;
				run_q    <= run_d;
				acc_q    <= acc_d;
				bidx_q   <= bidx_d;
			end
		end
	end

endmodule

// ===== sv/tgarle_queue.sv =====
module tgarle_queue #(
	parameter int unsigned DEPTH = tgarle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  tgarle_pkg::rec_t     push_rec,
	output logic                 space_ok,
	output tgarle_pkg::rec_chan_t head,
	input  logic                 pop
);
	import tgarle_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	rec_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign space_ok  = (cnt_q != CNT_FULL);
	assign head.valid = (cnt_q != '0);
	assign head.rec   = slots_q[rd_q];
	assign do_push   = push & space_ok;
	assign do_pop    = pop & head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/tgarle_back.sv =====
module tgarle_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tgarle_pkg::rec_chan_t                head,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tgarle_pkg::OUT_DATA_W-1:0]    out_data,
	output logic [1:0]                           out_user,
	output logic                                 out_last
);
	import tgarle_pkg::*;

	logic        valid_q;
	logic [1:0]  kind_q;
	logic [1:0]  code_q;
	logic [15:0] width_q, height_q;
	logic        alpha_q, fh_q, fv_q;
	logic [31:0] color_q, first_q;
	logic [7:0]  count_q;
	logic        last_q;

	assign pop = head.valid & (~valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= head.valid;
		end
	end

	// unpack the record into the result fields, zero where unused
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q   <= head.rec.kind;
			code_q   <= '0;
			width_q  <= '0;
			height_q <= '0;
			alpha_q  <= 1'b0;
			fh_q     <= 1'b0;
			fv_q     <= 1'b0;
			color_q  <= '0;
			first_q  <= '0;
			count_q  <= '0;
			last_q   <= 1'b0;
			unique case (head.rec.kind)
				KIND_HEADER: begin
					width_q  <= head.rec.data_a[15:0];
					height_q <= head.rec.data_a[31:16];
					alpha_q  <= head.rec.count[0];
					fh_q     <= head.rec.count[1];
					fv_q     <= head.rec.count[2];
					last_q   <= head.rec.last;
				end
				KIND_RUN: begin
					color_q <= head.rec.data_a;
					first_q <= head.rec.data_b;
					count_q <= head.rec.count;
					last_q  <= head.rec.last;
				end
				KIND_ERROR: code_q <= head.rec.code;
				default: ;
			endcase
		end
	end

	assign out_valid = valid_q;
	assign out_user  = kind_q;
	assign out_last  = last_q;
	assign out_data  = {3'b000, first_q, count_q, color_q, fv_q, fh_q, alpha_q,
		height_q, width_q, code_q};

endmodule

// ===== sv/tga_truecolor_rle_decoder_core.sv =====
// channel   dir  tdata                                   tuser       tlast
// s_axis    in   in_byte[7:0]                            start_file  -
// m_axis    out  error_code, image_width, image_height,  out_kind    last_of_image
//                has_alpha, flip_h, flip_v, pixel_color,
//                run_count, first_pixel (112 bits)
//
// one file byte per clock while the queue has room; results are queued, then registered
// the front parser decides each byte combinationally; the 16x16 pixel-total multiply is
// registered and used at the descriptor byte, two bytes after the height completes
// arst_n clears the parser to idle and empties the queue and output register
// an output stall fills the result queue; s_axis_tready drops only when it is full
module tga_truecolor_rle_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = tgarle_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// file bytes
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,  // [7:0] in_byte
	input  logic                              s_axis_tuser,  // [0] start_file
	// results
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [1:0] error_code, [17:2] image_width, [33:18] image_height, [34] has_alpha,
	// [35] flip_horizontal, [36] flip_vertical, [68:37] pixel_color,
	// [76:69] run_count, [108:77] first_pixel, [111:109] zero
	output logic [tgarle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic [1:0]                        m_axis_tuser,  // [1:0] out_kind
	output logic                              m_axis_tlast   // last_of_image
);
	import tgarle_pkg::*;

	logic      space_ok;
	logic      push;
	rec_t      push_rec;
	rec_chan_t head;
	logic      pop;

	// the front takes a byte whenever the queue has room, even when it makes no result
	assign s_axis_tready = space_ok;

	// byte parser: header, id skip, packet headers, color assembly
	tgarle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_data  (s_axis_tdata),
		.byte_start (s_axis_tuser),
		.space_ok   (space_ok),
		.push       (push),
		.push_rec   (push_rec)
	);

	// short result queue decoupling the parser from the output side
	tgarle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.space_ok (space_ok),
		.head     (head),
		.pop      (pop)
	);

	// result formatting into the output register
	tgarle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== tb/tb_tga_truecolor_rle_decoder_core.sv =====
module tb_tga_truecolor_rle_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tgarle_pkg::*;

	// header byte offsets within the 18-byte tga header
	localparam logic [4:0] HDR_ID_LEN     = 5'd0;
	localparam logic [4:0] HDR_CMAP_TYPE  = 5'd1;
	localparam logic [4:0] HDR_IMAGE_TYPE = 5'd2;
	localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
	localparam logic [4:0] HDR_DEPTH      = 5'd16;
	localparam logic [4:0] HDR_DESCRIPTOR = 5'd17;

	// header field values the decoder accepts
	localparam logic [7:0] TGA_TYPE_RAW = 8'd2;
	localparam logic [7:0] TGA_TYPE_RLE = 8'd10;
	localparam logic [7:0] TGA_DEPTH_24 = 8'd24;
	localparam logic [7:0] TGA_DEPTH_32 = 8'd32;
	localparam logic [7:0] DESC_FLIP_H  = 8'h10;
	localparam logic [7:0] DESC_FLIP_V  = 8'h20;
	localparam logic [7:0] PKT_RUN_BIT  = 8'h80;

	localparam int unsigned RESULT_LATENCY = 2;
	localparam int unsigned SENT_BYTE_TARGET = 1450;
	localparam int unsigned CYCLE_LIMIT = 400_000;

	// parser phases of the predictor
	typedef enum logic [2:0] {
		DEC_IDLE,
		DEC_HEADER,
		DEC_ID,
		DEC_PACKET,
		DEC_COLOR
	} dec_phase_t;

	// one decoded result, unpacked into the fields the block reports
	typedef struct {
		kind_t       kind;
		err_t        code;
		logic [15:0] width;
		logic [15:0] height;
		logic        alpha;
		logic        flip_h;
		logic        flip_v;
		logic [31:0] color;
		logic [7:0]  run_len;
		logic [31:0] first_px;
		logic        last;
	} tga_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	tga_truecolor_rle_decoder_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state, mirrors the decoder's own registers
	dec_phase_t  dec_phase  = DEC_IDLE;
	logic [4:0]  hdr_pos    = '0;
	logic [7:0]  id_left    = '0;
	bit          rle_mode   = 1'b0;
	logic [15:0] img_w      = '0;
	logic [15:0] img_h      = '0;
	bit          alpha32    = 1'b0;
	logic [1:0]  flips      = '0;
	logic [31:0] pix_total  = '0;
	logic [31:0] pix_next   = '0;
	logic [7:0]  pkt_left   = '0;
	bit          pkt_repeat = 1'b0;
	logic [31:0] color_acc  = '0;
	logic [1:0]  color_pos  = '0;

	tga_result_t predicted_results[$];
	logic [7:0]  file_bytes[$];

	int unsigned mismatch_count = 0;
	int unsigned sent_bytes = 0;   // byte transactions accepted so far
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake or a missing result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				predicted_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor
	function automatic tga_result_t blank_result(input kind_t k);
		tga_result_t r;
		r.kind     = k;
		r.code     = ERR_COLORMAP;
		r.width    = '0;
		r.height   = '0;
		r.alpha    = 1'b0;
		r.flip_h   = 1'b0;
		r.flip_v   = 1'b0;
		r.color    = '0;
		r.run_len  = '0;
		r.first_px = '0;
		r.last     = 1'b0;
		return r;
	endfunction

	// header rejected: one error transaction, then wait for the next file
	function automatic void post_error(input err_t code);
		tga_result_t r;
		r = blank_result(KIND_ERROR);
		r.code = code;
		predicted_results.push_back(r);
		dec_phase = DEC_IDLE;
	endfunction

	function automatic void start_pixel_data();
		color_acc = '0;
		color_pos = '0;
		if (pix_next >= pix_total)
			dec_phase = DEC_IDLE;
		else
			dec_phase = rle_mode ? DEC_PACKET : DEC_COLOR;
	endfunction

	// advances the predictor by one file byte
	function automatic void decode_file_byte(input logic [7:0] b, input logic sof);
		tga_result_t r;
		logic [4:0]  idx;
		logic [31:0] cnt;
		logic [31:0] px_left;
		if (sof) begin
			// a new file abandons whatever was in progress
			hdr_pos    = '0;
			id_left    = '0;
			rle_mode   = 1'b0;
			img_w      = '0;
			img_h      = '0;
			alpha32    = 1'b0;
			flips      = '0;
			pix_total  = '0;
			pix_next   = '0;
			pkt_left   = '0;
			pkt_repeat = 1'b0;
			color_acc  = '0;
			color_pos  = '0;
			dec_phase  = DEC_HEADER;
		end
		case (dec_phase)
			DEC_HEADER: begin
				idx = hdr_pos;
				hdr_pos = hdr_pos + 5'd1;
				case (idx)
					HDR_ID_LEN: id_left = b;
					HDR_CMAP_TYPE: begin
						if (b != 8'd0)
							post_error(ERR_COLORMAP);
					end
					HDR_IMAGE_TYPE: begin
						if (b != TGA_TYPE_RAW && b != TGA_TYPE_RLE)
							post_error(ERR_IMG_TYPE);
						else
							rle_mode = (b == TGA_TYPE_RLE);
					end
					HDR_WIDTH_LO: img_w = {8'h00, b};
					HDR_WIDTH_HI: img_w[15:8] = b;
					HDR_HEIGHT_LO: img_h = {8'h00, b};
					HDR_HEIGHT_HI: img_h[15:8] = b;
					HDR_DEPTH: begin
						if (b != TGA_DEPTH_32 && b != TGA_DEPTH_24)
							post_error(ERR_DEPTH);
						else
							alpha32 = (b == TGA_DEPTH_32);
					end
					HDR_DESCRIPTOR: begin
						flips[0] = (b & DESC_FLIP_H) != 8'd0;
						flips[1] = (b & DESC_FLIP_V) != 8'd0;
						pix_total = 32'(img_w) * 32'(img_h);
						pix_next = '0;
						r = blank_result(KIND_HEADER);
						r.width  = img_w;
						r.height = img_h;
						r.alpha  = alpha32;
						r.flip_h = flips[0];
						r.flip_v = flips[1];
						r.last   = (pix_total == 32'd0);
						predicted_results.push_back(r);
						// an empty image ends at the header, id field unread
						if (pix_total == 32'd0)
							dec_phase = DEC_IDLE;
						else if (id_left != 8'd0)
							dec_phase = DEC_ID;
						else
							start_pixel_data();
					end
					default: ;
				endcase
			end
			DEC_ID: begin
				id_left = id_left - 8'd1;
				if (id_left == 8'd0)
					start_pixel_data();
			end
			DEC_PACKET: begin
				// packet count is clamped to the pixels still missing
				cnt = 32'(b[6:0]) + 32'd1;
				px_left = pix_total - pix_next;
				if (px_left < cnt)
					cnt = px_left;
				pkt_left = cnt[7:0];
				pkt_repeat = (b & PKT_RUN_BIT) != 8'd0;
				color_acc = '0;
				color_pos = '0;
				dec_phase = DEC_COLOR;
			end
			DEC_COLOR: begin
				color_acc[color_pos * 8 +: 8] = b;
				if (color_pos < (alpha32 ? 2'd3 : 2'd2)) begin
					color_pos = color_pos + 2'd1;
				end else begin
					cnt = (rle_mode && pkt_repeat) ? 32'(pkt_left) : 32'd1;
					if (cnt == 32'd0)
						cnt = 32'd1;
					r = blank_result(KIND_RUN);
					r.color    = color_acc;
					r.run_len  = cnt[7:0];
					r.first_px = pix_next;
					pix_next   = pix_next + cnt;
					r.last     = (pix_next >= pix_total);
					predicted_results.push_back(r);
					color_acc = '0;
					color_pos = '0;
					if (rle_mode)
						pkt_left = (32'(pkt_left) >= cnt) ? pkt_left - cnt[7:0] : 8'd0;
					if (pix_next >= pix_total)
						dec_phase = DEC_IDLE;
					else if (rle_mode && pkt_left == 8'd0)
						dec_phase = DEC_PACKET;
				end
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- checking
	task automatic flag_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 50)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	// every output transaction is compared against the oldest prediction
	always @(posedge clk) begin : result_check
		tga_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (predicted_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result, kind %0d tdata 0x%0h",
					m_axis_tuser, m_axis_tdata));
			end else begin
				want = predicted_results.pop_front();
				check_field("out_kind", 32'(m_axis_tuser), 32'(want.kind));
				check_field("error_code", 32'(m_axis_tdata[1:0]), 32'(want.code));
				check_field("image_width", 32'(m_axis_tdata[17:2]), 32'(want.width));
				check_field("image_height", 32'(m_axis_tdata[33:18]), 32'(want.height));
				check_field("has_alpha", 32'(m_axis_tdata[34]), 32'(want.alpha));
				check_field("flip_horizontal", 32'(m_axis_tdata[35]), 32'(want.flip_h));
				check_field("flip_vertical", 32'(m_axis_tdata[36]), 32'(want.flip_v));
				check_field("pixel_color", m_axis_tdata[68:37], want.color);
				check_field("run_count", 32'(m_axis_tdata[76:69]), 32'(want.run_len));
				check_field("first_pixel", m_axis_tdata[108:77], want.first_px);
				check_field("tdata padding", 32'(m_axis_tdata[111:109]), 32'd0);
				check_field("last_of_image", 32'(m_axis_tlast), 32'(want.last));
			end
		end
	end

	// ---------------------------------------------------------------- receiver
	// output ready follows a changing pattern: open, coin flip, mostly open,
	// and long stalls that fill the result queue and push back on the input
	initial begin : output_stall_pattern
		int unsigned mode;
		int unsigned span;
		m_axis_tready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 150);
			for (int i = 0; i < span; i++) begin
				@(posedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 7) != 0);
					default: m_axis_tready <= (i % 12 == 0);
				endcase
			end
		end
	end

	// ---------------------------------------------------------------- sender
	// one byte transaction; bursts of random length with random gaps between
	task automatic send_byte(input logic [7:0] b, input logic sof);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 9) == 0) begin
				// a long stretch at full rate
				gap = 0;
				burst_left = $urandom_range(100, 300);
			end else begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
				burst_left = $urandom_range(1, 20);
			end
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= sof;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_file_byte(b, sof);
		sent_bytes++;
	endtask

	// input goes quiet until every predicted result has come out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (predicted_results.size() != 0)
			@(posedge clk);
	endtask

	// sends the built file up to a cut point; the first byte flags start of file
	task automatic send_file(input int unsigned cut);
		for (int i = 0; i < file_bytes.size() && i < cut; i++)
			send_byte(file_bytes[i], i == 0);
		file_bytes.delete();
	endtask

	// ---------------------------------------------------------------- file builder
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [31:0] pick_color();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic put_header(input logic [7:0] id_len, input logic [7:0] cmap,
			input logic [7:0] itype, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] depth, input logic [7:0] desc);
		file_bytes.push_back(id_len);
		file_bytes.push_back(cmap);
		file_bytes.push_back(itype);
		// colormap spec and origin fields, ignored by the decoder
		repeat (9) file_bytes.push_back(pick_byte());
		file_bytes.push_back(w[7:0]);
		file_bytes.push_back(w[15:8]);
		file_bytes.push_back(h[7:0]);
		file_bytes.push_back(h[15:8]);
		file_bytes.push_back(depth);
		file_bytes.push_back(desc);
		repeat (id_len) file_bytes.push_back(pick_byte());
	endtask

	// little-endian pixel, three or four bytes
	task automatic put_pixel(input logic [31:0] color, input bit four);
		file_bytes.push_back(color[7:0]);
		file_bytes.push_back(color[15:8]);
		file_bytes.push_back(color[23:16]);
		if (four)
			file_bytes.push_back(color[31:24]);
	endtask

	task automatic put_image_data(input bit rle, input bit four, input int unsigned total,
			input bit long_runs);
		int unsigned px_left;
		int unsigned cnt;
		bit          rep;
		px_left = total;
		if (!rle) begin
			repeat (total) put_pixel(pick_color(), four);
		end else begin
			while (px_left != 0) begin
				if (long_runs && $urandom_range(0, 4) != 0) begin
					cnt = $urandom_range(16, 128);
					rep = 1'b1;
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: cnt = $urandom_range(1, 6);
						6, 7: cnt = $urandom_range(7, 128);
						// overshoot: the decoder clamps at the image end
						8: cnt = (px_left < 128) ? $urandom_range(px_left, 128) : 128;
						default: cnt = (px_left < 128) ? px_left : 128;
					endcase
					rep = (cnt > 8) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
				end
				file_bytes.push_back({rep, 7'(cnt - 1)});
				if (rep)
					put_pixel(pick_color(), four);
				else
					repeat (cnt) put_pixel(pick_color(), four);
				px_left = (cnt >= px_left) ? 0 : px_left - cnt;
			end
		end
	endtask

	// a well-formed file with random content, mostly small
	task automatic put_random_image();
		bit          rle;
		bit          four;
		bit          big;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  id_len;
		rle  = 1'($urandom_range(0, 1));
		four = 1'($urandom_range(0, 1));
		big  = rle && ($urandom_range(0, 9) == 0);
		if (big) begin
			w = 16'($urandom_range(30, 300));
			h = 16'($urandom_range(1, 2));
		end else begin
			w = 16'($urandom_range(1, 6));
			h = 16'($urandom_range(1, 4));
		end
		case ($urandom_range(0, 39))
			0: w = 16'd0;
			1: h = 16'd0;
			default: ;
		endcase
		case ($urandom_range(0, 49))
			0: id_len = 8'($urandom_range(200, 255));
			1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12: id_len = 8'($urandom_range(1, 6));
			default: id_len = 8'd0;
		endcase
		put_header(id_len, 8'd0, rle ? TGA_TYPE_RLE : TGA_TYPE_RAW, w, h,
			four ? TGA_DEPTH_32 : TGA_DEPTH_24, pick_byte());
		put_image_data(rle, four, 32'(w) * 32'(h), big);
	endtask

	// ---------------------------------------------------------------- tests
	// bytes before any start of file are dropped silently
	task automatic test_idle_bytes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
	endtask

	// each header rejection, with the rest of the file dropped
	task automatic test_header_rejects();
		put_header(8'd0, 8'd1, TGA_TYPE_RAW, 16'd2, 16'd2, TGA_DEPTH_24, 8'h00);
		send_file(5);
		put_header(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, TGA_DEPTH_24, 8'h00);
		send_file(4);
		put_header(8'd0, 8'd0, 8'd0, 16'd2, 16'd2, TGA_DEPTH_24, 8'h00);
		send_file(3);
		put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd2, 16'd2, 8'd16, 8'h00);
		send_file(19);
	endtask

	// zero width or height: header marks the image done and the id field is not read
	task automatic test_empty_image();
		put_header(8'd3, 8'd0, TGA_TYPE_RLE, 16'd0, 16'd7, TGA_DEPTH_32, DESC_FLIP_V);
		send_file(file_bytes.size());
		put_header(8'd0, 8'd0, TGA_TYPE_RAW, 16'd5, 16'd0, TGA_DEPTH_24, 8'h00);
		send_file(file_bytes.size());
	endtask

	// uncompressed images in both depths, with id field, flips and trailing junk
	task automatic test_raw_images();
		put_header(8'd2, 8'd0, TGA_TYPE_RAW, 16'd2, 16'd2, TGA_DEPTH_24, DESC_FLIP_H);
		put_pixel(32'h00FF_FFFF, 1'b0);
		put_pixel(32'h0000_0000, 1'b0);
		put_pixel(32'h0012_3456, 1'b0);
		put_pixel(32'h00A5_5AC3, 1'b0);
		file_bytes.push_back(8'hFF);
		file_bytes.push_back(8'h00);
		send_file(file_bytes.size());
		put_header(8'd0, 8'd0, TGA_TYPE_RAW, 16'd1, 16'd2, TGA_DEPTH_32,
			DESC_FLIP_H | DESC_FLIP_V);
		put_pixel(32'hFFFF_FFFF, 1'b1);
		put_pixel(32'h0000_0000, 1'b1);
		send_file(file_bytes.size());
	endtask

	// run-length images: runs across scanlines, clamping, a full 128-pixel run
	task automatic test_rle_images();
		put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd2, 16'd3, TGA_DEPTH_24, 8'h00);
		file_bytes.push_back(PKT_RUN_BIT | 8'd2);   // three pixels, crosses a row
		put_pixel(32'h0011_2233, 1'b0);
		file_bytes.push_back(8'd1);                 // two raw pixels
		put_pixel(32'h00FF_0000, 1'b0);
		put_pixel(32'h0000_FF00, 1'b0);
		file_bytes.push_back(PKT_RUN_BIT | 8'h7F);  // 128 clamped to the last pixel
		put_pixel(32'h0000_00FF, 1'b0);
		send_file(file_bytes.size());
		put_header(8'd1, 8'd0, TGA_TYPE_RLE, 16'd16, 16'd9, TGA_DEPTH_32, DESC_FLIP_V);
		file_bytes.push_back(PKT_RUN_BIT | 8'h7F);  // full 128-pixel run
		put_pixel(32'hDEAD_BEEF, 1'b1);
		file_bytes.push_back(PKT_RUN_BIT | 8'h0F);
		put_pixel(32'h0102_0304, 1'b1);
		send_file(file_bytes.size());
		// raw packet longer than the image, tail pixels dropped
		put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd2, 16'd1, TGA_DEPTH_24, 8'h00);
		file_bytes.push_back(8'd3);
		repeat (4) put_pixel(pick_color(), 1'b0);
		send_file(file_bytes.size());
	endtask

	// largest header fields; the next file abandons the long id field
	task automatic test_header_extremes();
		put_header(8'd255, 8'd0, TGA_TYPE_RAW, 16'hFFFF, 16'hFFFF, TGA_DEPTH_32, 8'hFF);
		send_file(24);
	endtask

	// start of file in the middle of a header and of a pixel
	task automatic test_restart();
		put_header(8'd0, 8'd0, TGA_TYPE_RAW, 16'd4, 16'd4, TGA_DEPTH_24, 8'h00);
		send_file(9);
		put_header(8'd0, 8'd0, TGA_TYPE_RAW, 16'd4, 16'd4, TGA_DEPTH_24, 8'h00);
		repeat (16) put_pixel(pick_color(), 1'b0);
		send_file(25);
		put_header(8'd0, 8'd0, TGA_TYPE_RLE, 16'd1, 16'd1, TGA_DEPTH_32, 8'h00);
		file_bytes.push_back(8'd0);
		put_pixel(32'h8000_0001, 1'b1);
		send_file(file_bytes.size());
	endtask

	// mostly well-formed files, with broken headers, truncation and noise mixed in
	task automatic test_random_files();
		bit          drained;
		logic [7:0]  bad;
		int unsigned pick;
		drained = 1'b0;
		while (sent_bytes < SENT_BYTE_TARGET) begin
			if (!drained && sent_bytes > SENT_BYTE_TARGET / 2) begin
				wait_for_results();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				put_random_image();
				send_file(file_bytes.size());
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4)) send_byte(pick_byte(), 1'b0);
			end else if (pick < 84) begin
				case ($urandom_range(0, 2))
					0: put_header(8'd0, 8'($urandom_range(1, 255)), TGA_TYPE_RAW, 16'd2,
						16'd2, TGA_DEPTH_24, pick_byte());
					1: begin
						do bad = pick_byte(); while (bad == TGA_TYPE_RAW || bad == TGA_TYPE_RLE);
						put_header(8'd0, 8'd0, bad, 16'd2, 16'd2, TGA_DEPTH_24, pick_byte());
					end
					default: begin
						do bad = pick_byte(); while (bad == TGA_DEPTH_24 || bad == TGA_DEPTH_32);
						put_header(pick_byte(), 8'd0, TGA_TYPE_RLE, 16'($urandom),
							16'($urandom), bad, pick_byte());
					end
				endcase
				send_file(file_bytes.size());
			end else if (pick < 93) begin
				put_random_image();
				send_file($urandom_range(1, file_bytes.size() - 1));
			end else begin
				repeat ($urandom_range(1, 12))
					send_byte(pick_byte(), $urandom_range(0, 5) == 0);
			end
		end
	endtask

	// ---------------------------------------------------------------- main
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_bytes();
		test_header_rejects();
		test_empty_image();
		test_raw_images();
		test_rle_images();
		test_header_extremes();
		test_restart();
		test_random_files();

		// drain, then leave room for any stray result
		wait_for_results();
		repeat (4 * RESULT_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== tga_truecolor_rle_decoder_core.f =====
sv/tgarle_pkg.sv
sv/tgarle_front.sv
sv/tgarle_queue.sv
sv/tgarle_back.sv
sv/tga_truecolor_rle_decoder_core.sv
tb/tb_tga_truecolor_rle_decoder_core.sv
